[design/rbrb_pkg.sv]
package rbrb_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  localparam int unsigned FILL_W = 7;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;

  typedef struct packed {
    logic              pop;
    logic              hit;
    logic              empty;
    logic              dropped;
    logic [FILL_W-1:0] fill;
  } rsp_t;

endpackage

[design/rx_byte_ring_buffer.sv]
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   req_type_i, rx_byte_i
// out      out  out_valid_o / out_ready_i data_out_o, was_empty_o, dropped_oldest_o,
//                                         fill_count_o
// cfg      in   cfg_valid_i / cfg_ready_o cfg_map_cr_to_lf_i
//
// one item per cycle sustained while the output is not stalled; a result passes through the ram
// read register, loaded at the edge that takes its item, and then through the output register
// reset clears both ring indices and sets cr to lf mapping; ram contents stay undefined
// a stalled output holds one result and the ram stage holds one more before in_ready_o drops
// cfg_ready_o is always high
module rx_byte_ring_buffer #(
  parameter int unsigned DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o,
  output logic       was_empty_o,
  output logic       dropped_oldest_o,
  output logic [6:0] fill_count_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_map_cr_to_lf_i
);

  import rbrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic              in_fire;
  logic              s1_adv;
  logic              s1_v_q;
  rsp_t              s1_rsp_q;
  rsp_t              rsp;
  logic              map_q;
  logic              out_v_q;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              empty_q;
  logic              drop_q;
  logic [FILL_W-1:0] fill_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign s1_adv     = !out_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  rbrb_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_fire_i (in_fire),
    .req_type_i (req_type_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_raddr_o(ram_raddr),
    .rsp_o      (rsp)
  );

  rbrb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(rx_byte_i),
    .re_i   (in_fire),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (s1_rsp_q.empty) begin
      data_d = EMPTY_BYTE;
    end else if (s1_rsp_q.hit) begin
      if (s1_rsp_q.pop && map_q && ram_rdata == CR_BYTE) begin
        data_d = LF_BYTE;
      end else begin
        data_d = ram_rdata;
      end
    end else begin
      data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      map_q   <= 1'b1;
    end else begin
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= s1_v_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        map_q <= cfg_map_cr_to_lf_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_rsp_q <= rsp;
    end
    if (s1_adv && s1_v_q) begin
      data_q  <= data_d;
      empty_q <= s1_rsp_q.empty;
      drop_q  <= s1_rsp_q.dropped;
      fill_q  <= s1_rsp_q.fill;
    end
  end

  assign out_valid_o      = out_v_q;
  assign data_out_o       = data_q;
  assign was_empty_o      = empty_q;
  assign dropped_oldest_o = drop_q;
  assign fill_count_o     = fill_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_empty_o && dropped_oldest_o))
    else $error("empty and dropped both set");

  a_empty_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_empty_o) |-> (data_out_o == EMPTY_BYTE && fill_count_o == '0))
    else $error("empty result carries wrong data");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !out_ready_i) |-> !in_ready_o)
    else $error("item taken while both stages are full");

endmodule

[design/rbrb_ram.sv]
module rbrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/rbrb_ctrl.sv]
module rbrb_ctrl #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_fire_i,
  input  logic [1:0]               req_type_i,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  output rbrb_pkg::rsp_t           rsp_o
);

  import rbrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = (AW + 1 > FILL_W) ? AW + 1 : FILL_W;

  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] wr_next;
  logic [AW-1:0] rd_next;
  logic          is_empty;
  logic [FW-1:0] diff;

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    wr_next  = inc_idx(wr_q);
    rd_next  = inc_idx(rd_q);
    is_empty = (wr_q == rd_q);
    wr_d     = wr_q;
    rd_d     = rd_q;
    rsp_o    = '0;
    case (req_type_i)
      REQ_PUSH: begin
        wr_d = wr_next;
        if (wr_next == rd_q) begin
          rd_d          = rd_next;
          rsp_o.dropped = 1'b1;
        end
      end
      REQ_POP: begin
        if (is_empty) begin
          rsp_o.empty = 1'b1;
        end else begin
          rsp_o.hit = 1'b1;
          rsp_o.pop = 1'b1;
          rd_d      = rd_next;
        end
      end
      REQ_PEEK: begin
        if (is_empty) begin
          rsp_o.empty = 1'b1;
        end else begin
          rsp_o.hit = 1'b1;
        end
      end
      REQ_CLEAR: begin
        wr_d = '0;
        rd_d = '0;
      end
      default: begin
        wr_d = wr_q;
      end
    endcase
    diff = FW'(wr_d) - FW'(rd_d) + ((wr_d < rd_d) ? FW'(DEPTH) : '0);
    rsp_o.fill = diff[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else if (req_fire_i) begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  assign ram_we_o    = req_fire_i && (req_type_i == REQ_PUSH);
  assign ram_waddr_o = wr_q;
  assign ram_raddr_o = rd_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wr_q) < DEPTH) && (32'(rd_q) < DEPTH))
    else $error("ring index out of range");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire_i && req_type_i == REQ_CLEAR) |=> (wr_q == '0 && rd_q == '0))
    else $error("clear did not reset indices");

  a_drop_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire_i && rsp_o.dropped) |=> (rd_q == $past(rd_next) && wr_q == $past(wr_next)))
    else $error("overwrite did not advance both indices");

endmodule

[dv/tb_rx_byte_ring_buffer.sv]
`timescale 1ns / 1ps

module tb_rx_byte_ring_buffer;
  import rbrb_pkg::*;

  localparam int unsigned RING_DEPTH = 128;
  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    req_e        kind;
    logic [7:0]  rx;
  } ring_req_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        empty;
    logic        dropped;
    logic [6:0]  fill;
  } ring_rsp_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type = REQ_PUSH;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic [7:0] data_out_o;
  logic       was_empty_o;
  logic       dropped_oldest_o;
  logic [6:0] fill_count_o;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_map = 1'b1;

  rx_byte_ring_buffer #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .data_out_o        (data_out_o),
    .was_empty_o       (was_empty_o),
    .dropped_oldest_o  (dropped_oldest_o),
    .fill_count_o      (fill_count_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_map_cr_to_lf_i(cfg_map)
  );

  // predictor state
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [IDX_W-1:0] wr_idx = '0;
  logic [IDX_W-1:0] rd_idx = '0;
  logic             cr_map = 1'b1;

  ring_req_t  req_q[$];
  ring_rsp_t  ring_rsp_q[$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  int         holds_asked = 0;
  int         holds_served = 0;
  int         hold_left = 0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic ring_rsp_t ring_step_result(input req_e kind, input logic [7:0] rx);
    ring_rsp_t r;
    r = '0;
    case (kind)
      REQ_PUSH: begin
        ring_mem[wr_idx] = rx;
        wr_idx = wr_idx + 1'b1;
        if (wr_idx == rd_idx) begin
          rd_idx = rd_idx + 1'b1;
          r.dropped = 1'b1;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (wr_idx == rd_idx) begin
          r.data = EMPTY_BYTE;
          r.empty = 1'b1;
        end else begin
          r.data = ring_mem[rd_idx];
          if (kind == REQ_POP) begin
            rd_idx = rd_idx + 1'b1;
            if (cr_map && r.data == CR_BYTE) r.data = LF_BYTE;
          end
        end
      end
      default: begin
        wr_idx = '0;
        rd_idx = '0;
      end
    endcase
    r.fill = 7'(IDX_W'(wr_idx - rd_idx));
    return r;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    ring_req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      req_type <= REQ_PUSH;
      rx_byte  <= 8'h00;
    end else begin
      if (in_valid && in_ready_o) begin
        ring_rsp_q.push_back(ring_step_result(req_e'(req_type), rx_byte));
      end
      if (!in_valid || in_ready_o) begin
        if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          nxt = req_q.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt.kind;
          rx_byte  <= nxt.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with long holds on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic cmp_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    ring_rsp_t exp_r;
    if (rst_ni && out_valid_o && out_ready) begin
      if (ring_rsp_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual data %0h fill %0h",
                 $time, data_out_o, fill_count_o);
      end else begin
        exp_r = ring_rsp_q.pop_front();
        cmp_field("data_out", exp_r.data, data_out_o);
        cmp_field("was_empty", exp_r.empty, was_empty_o);
        cmp_field("dropped_oldest", exp_r.dropped, dropped_oldest_o);
        cmp_field("fill_count", exp_r.fill, fill_count_o);
      end
    end
  end

  task automatic add_req(input req_e kind, input logic [7:0] rx);
    ring_req_t r;
    r.kind = kind;
    r.rx = rx;
    req_q.push_back(r);
  endtask

  function automatic logic [7:0] rand_rx();
    return ($urandom_range(0, 3) == 0) ? CR_BYTE : 8'($urandom);
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_q.size() != 0 || in_valid || ring_rsp_q.size() != 0);
  endtask

  task automatic write_cr_map(input logic value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_map <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cr_map = value;
    cfg_valid <= 1'b0;
  endtask

  // push runs deep enough to overflow, pop runs to drain, clears and noise
  task automatic add_random_traffic(input int n);
    int added;
    int run;
    int mode;
    added = 0;
    while (added < n) begin
      mode = $urandom_range(0, 99);
      if (mode < 45) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 30);
        repeat (run) add_req(REQ_PUSH, rand_rx());
      end else if (mode < 80) begin
        run = $urandom_range(1, 30);
        repeat (run) add_req(($urandom_range(0, 4) == 0) ? REQ_PEEK : REQ_POP, 8'($urandom));
      end else if (mode < 90) begin
        run = $urandom_range(1, 4);
        repeat (run) add_req(REQ_PEEK, 8'($urandom));
      end else if (mode < 94) begin
        run = 1;
        add_req(REQ_CLEAR, 8'($urandom));
      end else begin
        run = $urandom_range(1, 10);
        repeat (run) add_req(req_e'($urandom_range(0, 3)), 8'($urandom));
      end
      added += run;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, mapping on after reset
    add_req(REQ_POP, 8'h00);
    add_req(REQ_PEEK, 8'hFF);
    add_req(REQ_PUSH, 8'h00);
    add_req(REQ_PUSH, 8'hFF);
    add_req(REQ_PUSH, CR_BYTE);
    add_req(REQ_PUSH, 8'hA5);
    add_req(REQ_PEEK, 8'h00);
    add_req(REQ_POP, 8'h00);
    add_req(REQ_POP, 8'hFF);
    add_req(REQ_POP, 8'h00);
    add_req(REQ_PEEK, 8'h00);
    add_req(REQ_POP, 8'h00);
    add_req(REQ_POP, 8'h00);
    add_req(REQ_PUSH, 8'h55);
    add_req(REQ_PUSH, 8'hAA);
    add_req(REQ_CLEAR, 8'hFF);
    add_req(REQ_POP, 8'h00);
    add_req(REQ_PEEK, 8'h00);
    wait_drained();

    // mapping off: carriage return passes through
    write_cr_map(1'b0);
    add_req(REQ_PUSH, CR_BYTE);
    add_req(REQ_PEEK, 8'h00);
    add_req(REQ_POP, 8'h00);
    add_req(REQ_PUSH, LF_BYTE);
    add_req(REQ_POP, 8'h00);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_cr_map(p[0] ? 1'b0 : 1'b1);
      if (p == 2) begin
        calm = 1'b1;
        holds_asked++;
      end
      if (p == 5) calm = 1'b1;
      add_random_traffic(250);
      wait_drained();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
design/rbrb_pkg.sv
design/rbrb_ram.sv
design/rbrb_ctrl.sv
design/rx_byte_ring_buffer.sv
dv/tb_rx_byte_ring_buffer.sv
